FILE: rtl/glu_pkg.sv
// glu_pkg: shared constants and types for the gcd / lcm unit
// no dependencies, used by gcd_lcm_unit_core
`timescale 1ns / 1ps
`default_nettype none

package glu_pkg;

    localparam int RESULT_WIDTH = 31;
    localparam int STATUS_WIDTH = 2;
    localparam int M_TDATA_WIDTH = 64;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [RESULT_WIDTH-1:0] lcm_value;
        logic [RESULT_WIDTH-1:0] gcd_value;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/gcd_lcm_unit_core.sv
// gcd_lcm_unit_core: gcd and lcm of two signed operands with a status code
// binary gcd, bit-serial restoring divide and bit-serial multiply
// depends on glu_pkg
//
// slave channel: one beat carries operand_a and operand_b; s_tready is high
// only while the unit is idle, so one pair is worked on at a time
// master channel: one result beat per operand beat, held in an output
// register; the next pair is accepted and worked on while it waits
// sequence: a pair with a zero or negative operand goes from idle straight
// to the done state; otherwise the binary gcd loop runs (one subtract or
// halving a cycle, every subtract followed by a halving), the common power
// of two is shifted back one bit a cycle, then a/gcd is found one quotient
// bit a cycle and (a/gcd)*b one multiplier bit a cycle
// stall: a finished result waits in the last state until the output
// register is free; reset empties the output register and returns to idle
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit_core #(
    parameter int OPERAND_WIDTH = 32,
    localparam int S_TDATA_WIDTH = ((2 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0]           s_tdata,  // operand_a, operand_b, zero pad
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [glu_pkg::M_TDATA_WIDTH-1:0]       m_tdata   // gcd_value, lcm_value, status
);

    localparam int W = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_SHL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W-1:0]    u_reg, u_next;
    logic [W-1:0]    v_reg, v_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [KW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            inval_reg, inval_next;
    logic            out_valid_reg, out_valid_next;
    glu_pkg::result_t out_reg, out_next;

    logic [W-1:0]    in_a, in_b;
    logic            in_ok;
    logic            accept;
    logic [W-1:0]    rem_shift;
    logic [W:0]      trial;
    logic [W:0]      prod_sum;
    logic [W+30:0]   gcd_ext, lcm_ext;
    glu_pkg::result_t res;

    assign in_a   = s_tdata[W-1:0];
    assign in_b   = s_tdata[2*W-1:W];
    assign in_ok  = (in_a != '0) && !in_a[W-1] && (in_b != '0) && !in_b[W-1];
    assign accept = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // restoring divide step, remainder in v, dividend / quotient in a
    assign rem_shift = {v_reg[W-2:0], a_reg[W-1]};
    assign trial     = {1'b0, rem_shift} - {1'b0, u_reg};

    // msb-first shift-add multiply, accumulator in v
    assign prod_sum = {v_reg, 1'b0} + (a_reg[W-1] ? {1'b0, b_reg} : {(W+1){1'b0}});

    assign gcd_ext = {31'd0, u_reg};
    assign lcm_ext = {31'd0, v_reg};

    always_comb
    begin
        res.gcd_value = gcd_ext[30:0];
        res.lcm_value = lcm_ext[30:0];
        res.status    = glu_pkg::STATUS_OK;
        if (inval_reg)
        begin
            res.gcd_value = '0;
            res.lcm_value = '0;
            res.status    = glu_pkg::STATUS_INVALID;
        end
        else if (ovf_reg)
        begin
            res.lcm_value = '0;
            res.status    = glu_pkg::STATUS_OVERFLOW;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        inval_next     = inval_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next     = in_a;
                    b_next     = in_b;
                    u_next     = in_a;
                    v_next     = in_b;
                    k_next     = '0;
                    ovf_next   = 1'b0;
                    inval_next = !in_ok;
                    state_next = in_ok ? ST_GCD : ST_DONE;
                end
            end
            ST_GCD:
            begin
                if (u_reg == v_reg)
                begin
                    cnt_next = KW'(W - 1);
                    if (k_reg == '0)
                    begin
                        v_next     = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_SHL;
                    end
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg > v_reg)
                begin
                    u_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            ST_SHL:
            begin
                u_next = u_reg << 1;
                k_next = k_reg - 1'b1;
                if (k_reg == KW'(1))
                begin
                    v_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!trial[W])
                begin
                    v_next = trial[W-1:0];
                    a_next = {a_reg[W-2:0], 1'b1};
                end
                else
                begin
                    v_next = rem_shift;
                    a_next = {a_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = KW'(W - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // the first multiply step loads v directly
                v_next = prod_sum[W-1:0];
                if (cnt_reg == KW'(W - 1))
                begin
                    v_next = a_reg[W-1] ? b_reg : '0;
                end
                else if (prod_sum[W] || prod_sum[W-1])
                begin
                    ovf_next = 1'b1;
                end
                a_next   = a_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        ovf_reg   <= ovf_next;
        inval_reg <= inval_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

FILE: test/tb_gcd_lcm_unit_core.sv
// tb_gcd_lcm_unit_core: self-checking bench for the gcd / lcm unit, stream in and out
// a scoreboard class predicts gcd, lcm and status per operand beat; random idling on both sides
// depends on glu_pkg and gcd_lcm_unit_core
`timescale 1ns / 1ps

module tb_gcd_lcm_unit_core;

    localparam int OP_W = 32;
    localparam int S_W = ((2 * OP_W + 7) / 8) * 8;
    localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam int RANDOM_PER_PHASE = 260;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;

    class gcd_lcm_scoreboard;
        glu_pkg::result_t pending_results[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        function void note_pair(logic [OP_W-1:0] a, logic [OP_W-1:0] b);
            glu_pkg::result_t res;
            logic [63:0] x;
            logic [63:0] y;
            logic [63:0] r;
            logic [63:0] q;
            logic [63:0] prod;
            res = '0;
            if (a == '0 || a[OP_W-1] || b == '0 || b[OP_W-1])
            begin
                res.status = glu_pkg::STATUS_INVALID;
            end
            else
            begin
                // euclid
                x = 64'(a);
                y = 64'(b);
                while (y != 0)
                begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                q = 64'(a) / x;
                res.gcd_value = x[glu_pkg::RESULT_WIDTH-1:0];
                if (q > POS_MAX / 64'(b))
                begin
                    res.status = glu_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    prod = q * 64'(b);
                    res.lcm_value = prod[glu_pkg::RESULT_WIDTH-1:0];
                    res.status = glu_pkg::STATUS_OK;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [glu_pkg::M_TDATA_WIDTH-1:0] beat);
            glu_pkg::result_t got;
            glu_pkg::result_t exp;
            got = beat;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $time, beat);
                fail_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.gcd_value !== exp.gcd_value)
                begin
                    $display("%0t: gcd_value expected %0d actual %0d",
                             $time, exp.gcd_value, got.gcd_value);
                    fail_count++;
                end
                if (got.lcm_value !== exp.lcm_value)
                begin
                    $display("%0t: lcm_value expected %0d actual %0d",
                             $time, exp.lcm_value, got.lcm_value);
                    fail_count++;
                end
                if (got.status !== exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.status, got.status);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [glu_pkg::M_TDATA_WIDTH-1:0] m_tdata;

    int unsigned src_idle = 0;
    int unsigned sink_stall = 0;
    int unsigned cycle_count = 0;

    gcd_lcm_scoreboard sb = new();

    gcd_lcm_unit_core #(
        .OPERAND_WIDTH(OP_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check every accepted beat, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    task automatic send_pair(input logic [OP_W-1:0] a, input logic [OP_W-1:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom};
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_pair(a, b);
    endtask

    task automatic send_random_pair();
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
        logic [63:0] g;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (pick < 25)
        begin
            // one operand zero or negative
            a = $urandom_range(1, 100000);
            b = ($urandom_range(1) == 0) ? '0 : ($urandom | 32'h8000_0000);
            if ($urandom_range(1) == 0)
            begin
                {a, b} = {b, a};
            end
        end
        else if (pick < 60)
        begin
            // shared factor, small sizes
            g = $urandom_range(1, 1000);
            a = OP_W'(g * $urandom_range(1, 5000));
            b = OP_W'(g * $urandom_range(1, 5000));
        end
        else if (pick < 75)
        begin
            a = $urandom & 32'h7FFF_FFFF;
            b = $urandom & 32'h7FFF_FFFF;
            if (a == '0)
            begin
                a = 1;
            end
        end
        else if (pick < 90)
        begin
            // lcm right around the positive limit
            a = $urandom_range(1, 65535);
            g = POS_MAX / 64'(a) + $urandom_range(0, 2);
            b = OP_W'(g);
        end
        else
        begin
            a = OP_W'($urandom_range(1, 255)) << $urandom_range(0, 23);
            b = OP_W'($urandom_range(1, 255)) << $urandom_range(0, 23);
        end
        send_pair(a, b);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle = 0;
                    sink_stall = 0;
                end
                1:
                begin
                    src_idle = 66;
                    sink_stall = 0;
                end
                2:
                begin
                    src_idle = 0;
                    sink_stall = 66;
                end
                default:
                begin
                    src_idle = 27;
                    sink_stall = 27;
                end
            endcase

            if (phase == 0)
            begin
                send_pair(32'd1, 32'd1);
                send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
                send_pair(32'h7FFF_FFFF, 32'd1);
                send_pair(32'd1, 32'h7FFF_FFFF);
                send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
                send_pair(32'd0, 32'd5);
                send_pair(32'd5, 32'd0);
                send_pair(32'd0, 32'd0);
                send_pair(32'hFFFF_FFFF, 32'd5);
                send_pair(32'd5, 32'hFFFF_FFFF);
                send_pair(32'h8000_0000, 32'h8000_0000);
                send_pair(32'h8000_0000, 32'd1);
                send_pair(32'd65536, 32'd65537);
                send_pair(32'd46340, 32'd46341);
                send_pair(32'd46341, 32'd46342);
                send_pair(32'h4000_0000, 32'd2);
                send_pair(32'h4000_0000, 32'd3);
                send_pair(32'd12, 32'd18);
                send_pair(32'd1024, 32'd768);
                send_pair(32'd7, 32'd7);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_random_pair();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/glu_pkg.sv
rtl/gcd_lcm_unit_core.sv
test/tb_gcd_lcm_unit_core.sv
